FILE: rtl/mfs_pkg.sv
// Shared types and constants for the multilevel feedback scheduler.
`timescale 1ns / 1ps
package mfs_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int MAX_LEVELS = 8;

  localparam int TASK_W  = 4;
  localparam int LVL_W   = 3;
  localparam int LVLC_W  = 4;
  localparam int CNT_W   = 5;
  localparam int REM_W   = 16;
  localparam int USE_W   = 8;
  localparam int TIME_W  = 32;
  localparam int QA_W    = LVL_W + TASK_W;
  localparam int Q_DEPTH = MAX_LEVELS * MAX_TASKS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEMOTE_AFTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT    = 2'd2;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_BEGIN,
    ST_INS_CMP,
    ST_INS_END,
    ST_AGE_LV,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_AGE_NEXT,
    ST_RUN_FIND,
    ST_RUN_RD,
    ST_RUN_POP,
    ST_RES
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ARRIVE,
    CMD_TICK,
    CMD_INS_BEGIN,
    CMD_INS_CMP,
    CMD_INS_END,
    CMD_AGE_LV,
    CMD_AGE_RD,
    CMD_AGE_CHK,
    CMD_AGE_NEXT,
    CMD_RUN_FIND,
    CMD_RUN_RD,
    CMD_RUN_POP,
    CMD_RES
  } dp_cmd_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic lift;
    logic last_lift;
    logic age_done;
    logic agen_zero;
    logic aged;
    logic top_found;
    logic run_long;
    logic demote;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/mfs_if.sv
// Channel interfaces for the scheduler: input words, result words and register writes.
`timescale 1ns / 1ps
interface mfs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [mfs_pkg::TASK_W-1:0] task_id;
  logic [mfs_pkg::LVL_W-1:0]  start_level;
  logic [mfs_pkg::REM_W-1:0]  burst;
  modport source(output valid, op, task_id, start_level, burst, input ready);
  modport sink(input valid, op, task_id, start_level, burst, output ready);
endinterface

interface mfs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       busy_res;
  logic [mfs_pkg::TASK_W-1:0] running_task;
  logic [mfs_pkg::LVL_W-1:0]  run_level;
  logic                       finished;
  logic [mfs_pkg::TIME_W-1:0] slice_start;
  modport source(output valid, busy_res, running_task, run_level, finished, slice_start,
                 input ready);
  modport sink(input valid, busy_res, running_task, run_level, finished, slice_start,
               output ready);
endinterface

interface mfs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mfs_pkg::CFG_IDX_W-1:0]  index;
  logic [mfs_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/mfs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mfs_ctrl.sv
// Scheduler controller: sequences arrivals, aging, running and result hand-off.
`timescale 1ns / 1ps
module mfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  mfs_pkg::dp_status_t st,
  output mfs_pkg::dp_cmd_t    cmd
);

  mfs_pkg::state_t state_r, state_nxt;
  mfs_pkg::state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfs_pkg::ST_IDLE;
      ret_r   <= mfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // The insert sequence is shared by arrivals, promotion and demotion; ret_r
  // remembers where to resume once it completes.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      mfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == mfs_pkg::OP_TICK) begin
            state_nxt = mfs_pkg::ST_AGE_LV;
          end else begin
            state_nxt = mfs_pkg::ST_INS_BEGIN;
            ret_nxt   = mfs_pkg::ST_IDLE;
          end
        end
      end
      mfs_pkg::ST_INS_BEGIN: begin
        if (st.q_full) state_nxt = ret_r;
        else if (st.q_empty) state_nxt = mfs_pkg::ST_INS_END;
        else state_nxt = mfs_pkg::ST_INS_CMP;
      end
      mfs_pkg::ST_INS_CMP: begin
        if (!st.lift || st.last_lift) state_nxt = mfs_pkg::ST_INS_END;
      end
      mfs_pkg::ST_INS_END: state_nxt = ret_r;
      mfs_pkg::ST_AGE_LV: begin
        if (st.age_done) state_nxt = mfs_pkg::ST_RUN_FIND;
        else if (!st.q_empty) state_nxt = mfs_pkg::ST_AGE_RD;
      end
      mfs_pkg::ST_AGE_RD: state_nxt = mfs_pkg::ST_AGE_CHK;
      mfs_pkg::ST_AGE_CHK: begin
        if (st.aged) begin
          state_nxt = mfs_pkg::ST_INS_BEGIN;
          ret_nxt   = mfs_pkg::ST_AGE_NEXT;
        end else begin
          state_nxt = mfs_pkg::ST_AGE_NEXT;
        end
      end
      mfs_pkg::ST_AGE_NEXT: begin
        state_nxt = st.agen_zero ? mfs_pkg::ST_AGE_LV : mfs_pkg::ST_AGE_RD;
      end
      mfs_pkg::ST_RUN_FIND: begin
        state_nxt = st.top_found ? mfs_pkg::ST_RUN_RD : mfs_pkg::ST_RES;
      end
      mfs_pkg::ST_RUN_RD: begin
        if (st.run_long && st.demote) begin
          state_nxt = mfs_pkg::ST_INS_BEGIN;
          ret_nxt   = mfs_pkg::ST_RUN_POP;
        end else begin
          state_nxt = mfs_pkg::ST_RES;
        end
      end
      mfs_pkg::ST_RUN_POP: state_nxt = mfs_pkg::ST_RES;
      mfs_pkg::ST_RES: begin
        if (st.out_free) state_nxt = mfs_pkg::ST_IDLE;
      end
      default: state_nxt = mfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = mfs_pkg::CMD_NONE;
    case (state_r)
      mfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = (in_op == mfs_pkg::OP_TICK) ? mfs_pkg::CMD_TICK : mfs_pkg::CMD_ARRIVE;
        end
      end
      mfs_pkg::ST_INS_BEGIN: cmd = mfs_pkg::CMD_INS_BEGIN;
      mfs_pkg::ST_INS_CMP:   cmd = mfs_pkg::CMD_INS_CMP;
      mfs_pkg::ST_INS_END:   cmd = mfs_pkg::CMD_INS_END;
      mfs_pkg::ST_AGE_LV:    cmd = mfs_pkg::CMD_AGE_LV;
      mfs_pkg::ST_AGE_RD:    cmd = mfs_pkg::CMD_AGE_RD;
      mfs_pkg::ST_AGE_CHK:   cmd = mfs_pkg::CMD_AGE_CHK;
      mfs_pkg::ST_AGE_NEXT:  cmd = mfs_pkg::CMD_AGE_NEXT;
      mfs_pkg::ST_RUN_FIND:  cmd = mfs_pkg::CMD_RUN_FIND;
      mfs_pkg::ST_RUN_RD:    cmd = mfs_pkg::CMD_RUN_RD;
      mfs_pkg::ST_RUN_POP:   cmd = mfs_pkg::CMD_RUN_POP;
      mfs_pkg::ST_RES: begin
        if (st.out_free) cmd = mfs_pkg::CMD_RES;
      end
      default: cmd = mfs_pkg::CMD_NONE;
    endcase
  end

endmodule

FILE: rtl/mfs_dp.sv
// Scheduler datapath: queue memory, per-task tables, queue pointers and result register.
`timescale 1ns / 1ps
module mfs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mfs_pkg::dp_cmd_t                 cmd,
  output mfs_pkg::dp_status_t              st,
  input  logic [mfs_pkg::TASK_W-1:0]       in_task_id,
  input  logic [mfs_pkg::LVL_W-1:0]        in_start_level,
  input  logic [mfs_pkg::REM_W-1:0]        in_burst,
  input  logic                             cfg_valid,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_busy_res,
  output logic [mfs_pkg::TASK_W-1:0]       out_running_task,
  output logic [mfs_pkg::LVL_W-1:0]        out_run_level,
  output logic                             out_finished,
  output logic [mfs_pkg::TIME_W-1:0]       out_slice_start
);

  localparam int TW = mfs_pkg::TASK_W;
  localparam int LW = mfs_pkg::LVL_W;

  // Configuration
  logic [mfs_pkg::LVLC_W-1:0] lvl_cnt_r;
  logic [mfs_pkg::USE_W-1:0]  dem_r;
  logic [mfs_pkg::REM_W-1:0]  age_r;

  // Queue pointers and time
  logic [TW-1:0]             heads_r  [mfs_pkg::MAX_LEVELS];
  logic [mfs_pkg::CNT_W-1:0] counts_r [mfs_pkg::MAX_LEVELS];
  logic [mfs_pkg::TIME_W-1:0] now_r;

  // Per-task tables
  logic [mfs_pkg::REM_W-1:0]  rem_r [mfs_pkg::MAX_TASKS];
  logic [mfs_pkg::USE_W-1:0]  use_r [mfs_pkg::MAX_TASKS];
  logic [mfs_pkg::TIME_W-1:0] lrt_r [mfs_pkg::MAX_TASKS];

  // Work registers
  logic [LW-1:0]             ins_lv_r;
  logic [TW-1:0]             ins_t_r;
  logic [mfs_pkg::REM_W-1:0] ins_rem_r;
  logic [TW-1:0]             ins_i_r;
  logic [LW-1:0]             cur_lv_r;
  logic [mfs_pkg::CNT_W-1:0] agen_r;
  logic [LW-1:0]             run_lv_r;
  logic                      res_busy_r;
  logic                      res_fin_r;
  logic [TW-1:0]             res_task_r;
  logic [LW-1:0]             res_lv_r;

  // Result register
  logic                       out_valid_r;
  logic                       out_busy_r;
  logic [TW-1:0]              out_task_r;
  logic [LW-1:0]              out_lv_r;
  logic                       out_fin_r;
  logic [mfs_pkg::TIME_W-1:0] out_slice_r;

  // Queue memory
  logic              q_we;
  logic [mfs_pkg::QA_W-1:0] q_waddr;
  logic [TW-1:0]     q_wdata;
  logic              q_re;
  logic [mfs_pkg::QA_W-1:0] q_raddr;
  logic [TW-1:0]     rd_q;

  logic [mfs_pkg::LVLC_W-1:0] levels;
  logic [LW-1:0]              start_lv;
  logic [LW-1:0]              top;
  logic                       top_found;
  logic [LW-1:0]              lix;
  logic [TW-1:0]              head_l;
  logic [mfs_pkg::CNT_W-1:0]  cnt_l;
  logic [TW-1:0]              pos_tail;
  logic [TW-1:0]              pos_lift;
  logic [TW-1:0]              tix;
  logic [mfs_pkg::REM_W-1:0]  rem_t;
  logic [mfs_pkg::USE_W-1:0]  use_t;
  logic [mfs_pkg::USE_W-1:0]  use_new;
  logic [mfs_pkg::TIME_W-1:0] lrt_t;
  logic [mfs_pkg::TIME_W-1:0] wait_t;

  mfs_ram #(
    .WIDTH(TW),
    .DEPTH(mfs_pkg::Q_DEPTH)
  ) u_qram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .re   (q_re),
    .raddr(q_raddr),
    .rdata(rd_q)
  );

  always_comb begin
    if (lvl_cnt_r == '0) begin
      levels = mfs_pkg::LVLC_W'(1);
    end else if (lvl_cnt_r > mfs_pkg::LVLC_W'(mfs_pkg::MAX_LEVELS)) begin
      levels = mfs_pkg::LVLC_W'(mfs_pkg::MAX_LEVELS);
    end else begin
      levels = lvl_cnt_r;
    end
  end

  always_comb begin
    logic [mfs_pkg::LVLC_W-1:0] top_m1;
    top_m1 = levels - mfs_pkg::LVLC_W'(1);
    if ({1'b0, in_start_level} >= levels) start_lv = top_m1[LW-1:0];
    else start_lv = in_start_level;
  end

  // Highest non-empty level among those in use; later levels override.
  always_comb begin
    top       = '0;
    top_found = 1'b0;
    for (int l = 0; l < mfs_pkg::MAX_LEVELS; l++) begin
      if (mfs_pkg::LVLC_W'(l) < levels && counts_r[l] != '0) begin
        top       = LW'(l);
        top_found = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd)
      mfs_pkg::CMD_INS_BEGIN, mfs_pkg::CMD_INS_CMP, mfs_pkg::CMD_INS_END: lix = ins_lv_r;
      mfs_pkg::CMD_AGE_LV, mfs_pkg::CMD_AGE_RD, mfs_pkg::CMD_AGE_CHK: lix = cur_lv_r;
      mfs_pkg::CMD_RUN_FIND: lix = top;
      default: lix = run_lv_r;
    endcase
  end

  assign head_l   = heads_r[lix];
  assign cnt_l    = counts_r[lix];
  assign pos_tail = head_l + cnt_l[TW-1:0];
  assign pos_lift = pos_tail + TW'(1) + ins_i_r;

  assign tix     = (cmd == mfs_pkg::CMD_INS_BEGIN) ? ins_t_r : rd_q;
  assign rem_t   = rem_r[tix];
  assign use_t   = use_r[tix];
  assign lrt_t   = lrt_r[tix];
  assign use_new = (use_t == '1) ? use_t : use_t + mfs_pkg::USE_W'(1);
  assign wait_t  = now_r - lrt_t;

  always_comb begin
    st.q_full    = cnt_l[mfs_pkg::CNT_W-1];
    st.q_empty   = (cnt_l == '0);
    st.lift      = (rem_t > ins_rem_r);
    st.last_lift = ({1'b0, ins_i_r} + mfs_pkg::CNT_W'(1) == cnt_l);
    st.age_done  = ({1'b0, cur_lv_r} + mfs_pkg::LVLC_W'(1) >= levels);
    st.agen_zero = (agen_r == '0);
    st.aged      = (wait_t >= {{(mfs_pkg::TIME_W - mfs_pkg::REM_W){1'b0}}, age_r});
    st.top_found = top_found;
    st.run_long  = (rem_t > mfs_pkg::REM_W'(1));
    st.demote    = (use_new == dem_r) && (run_lv_r != '0);
    st.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = {lix, pos_tail};
    q_wdata = rd_q;
    q_re    = 1'b0;
    q_raddr = {lix, head_l};
    case (cmd)
      mfs_pkg::CMD_INS_BEGIN: begin
        q_we    = !cnt_l[mfs_pkg::CNT_W-1];
        q_wdata = ins_t_r;
        q_re    = 1'b1;
      end
      mfs_pkg::CMD_INS_CMP: begin
        // A lifted entry moves behind the newcomer; reads stay ahead of these writes.
        q_we    = st.lift;
        q_waddr = {lix, pos_lift};
        q_re    = 1'b1;
        q_raddr = {lix, head_l + ins_i_r + TW'(1)};
      end
      mfs_pkg::CMD_AGE_RD:   q_re = 1'b1;
      mfs_pkg::CMD_AGE_CHK:  q_we = !st.aged;
      mfs_pkg::CMD_RUN_FIND: q_re = 1'b1;
      default: q_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_cnt_r   <= mfs_pkg::LVLC_W'(8);
      dem_r       <= mfs_pkg::USE_W'(4);
      age_r       <= mfs_pkg::REM_W'(100);
      now_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < mfs_pkg::MAX_LEVELS; l++) begin
        heads_r[l]  <= '0;
        counts_r[l] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mfs_pkg::REG_LEVEL_COUNT:  lvl_cnt_r <= cfg_data[mfs_pkg::LVLC_W-1:0];
          mfs_pkg::REG_DEMOTE_AFTER: dem_r     <= cfg_data[mfs_pkg::USE_W-1:0];
          mfs_pkg::REG_AGE_LIMIT:    age_r     <= cfg_data[mfs_pkg::REM_W-1:0];
          default: ;
        endcase
      end
      if (cmd == mfs_pkg::CMD_RES) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd)
        mfs_pkg::CMD_INS_END: begin
          heads_r[lix]  <= head_l + ins_i_r;
          counts_r[lix] <= cnt_l + mfs_pkg::CNT_W'(1);
        end
        mfs_pkg::CMD_AGE_CHK: begin
          heads_r[lix] <= head_l + TW'(1);
          if (st.aged) counts_r[lix] <= cnt_l - mfs_pkg::CNT_W'(1);
        end
        mfs_pkg::CMD_RUN_RD: begin
          if (!st.run_long) begin
            heads_r[lix]  <= head_l + TW'(1);
            counts_r[lix] <= cnt_l - mfs_pkg::CNT_W'(1);
          end
        end
        mfs_pkg::CMD_RUN_POP: begin
          heads_r[lix]  <= head_l + TW'(1);
          counts_r[lix] <= cnt_l - mfs_pkg::CNT_W'(1);
        end
        mfs_pkg::CMD_RES: begin
          now_r <= now_r + mfs_pkg::TIME_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      mfs_pkg::CMD_ARRIVE: begin
        rem_r[in_task_id] <= in_burst;
        use_r[in_task_id] <= '0;
        lrt_r[in_task_id] <= now_r;
        ins_t_r           <= in_task_id;
        ins_lv_r          <= start_lv;
      end
      mfs_pkg::CMD_TICK: cur_lv_r <= '0;
      mfs_pkg::CMD_INS_BEGIN: begin
        ins_rem_r <= rem_t;
        ins_i_r   <= '0;
      end
      mfs_pkg::CMD_INS_CMP: begin
        if (st.lift) ins_i_r <= ins_i_r + TW'(1);
      end
      mfs_pkg::CMD_AGE_LV: begin
        agen_r <= cnt_l;
        if (!st.age_done && st.q_empty) cur_lv_r <= cur_lv_r + LW'(1);
      end
      mfs_pkg::CMD_AGE_CHK: begin
        agen_r <= agen_r - mfs_pkg::CNT_W'(1);
        if (st.aged) begin
          lrt_r[rd_q] <= now_r;
          ins_lv_r    <= cur_lv_r + LW'(1);
          ins_t_r     <= rd_q;
        end
      end
      mfs_pkg::CMD_AGE_NEXT: begin
        if (st.agen_zero) cur_lv_r <= cur_lv_r + LW'(1);
      end
      mfs_pkg::CMD_RUN_FIND: begin
        run_lv_r   <= top;
        res_busy_r <= top_found;
        res_lv_r   <= top_found ? top : '0;
        res_task_r <= '0;
        res_fin_r  <= 1'b0;
      end
      mfs_pkg::CMD_RUN_RD: begin
        res_task_r  <= rd_q;
        lrt_r[rd_q] <= now_r + mfs_pkg::TIME_W'(1);
        if (st.run_long) begin
          rem_r[rd_q] <= rem_t - mfs_pkg::REM_W'(1);
          if (st.demote) begin
            use_r[rd_q] <= '0;
            ins_lv_r    <= run_lv_r - LW'(1);
            ins_t_r     <= rd_q;
          end else begin
            use_r[rd_q] <= use_new;
          end
        end else begin
          use_r[rd_q] <= use_new;
          res_fin_r   <= 1'b1;
        end
      end
      mfs_pkg::CMD_RES: begin
        out_busy_r  <= res_busy_r;
        out_task_r  <= res_task_r;
        out_lv_r    <= res_lv_r;
        out_fin_r   <= res_fin_r;
        out_slice_r <= now_r;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_busy_res     = out_busy_r;
  assign out_running_task = out_task_r;
  assign out_run_level    = out_lv_r;
  assign out_finished     = out_fin_r;
  assign out_slice_start  = out_slice_r;

endmodule

FILE: rtl/multilevel_feedback_scheduler.sv
// Multilevel feedback queue scheduler with aging and demotion (top level).
//
// Channels: in_ch takes words of two kinds. An arrive word (op 0) records a
// task's burst and queues it at its start level; it gives no result. A tick
// word (op 1) ages the waiting tasks, runs the front task of the highest
// non-empty level for one unit and gives exactly one word on out_ch. cfg_ch
// writes level_count (0), demote_after (1) and age_limit (2) and is always
// ready; it is to be written only while no word is in flight, and the block
// itself does not enforce this. Words are handled one at a time. An insert
// compares the newcomer with the entries of its level in turn: those moved
// behind the newcomer and the first one that stays. An arrive word runs one
// insert. A busy tick steps through the levels in use, checks each entry
// waiting below the top level for aging, then reads the front task of the top
// level; each promotion and each demotion runs an insert. An idle tick runs no
// task. The queue memory gives one registered read per cycle.
// The result sits in an output register; a stalled receiver holds the next
// tick at its final step until that register frees.
// Reset (synchronous, rst_n low) empties every queue, zeroes time and loads
// the register defaults; the queue memory needs no clearing.
`timescale 1ns / 1ps
module multilevel_feedback_scheduler (
  input logic      clk,
  input logic      rst_n,
  mfs_in_if.sink   in_ch,
  mfs_out_if.source out_ch,
  mfs_cfg_if.sink  cfg_ch
);

  mfs_pkg::dp_cmd_t    cmd;
  mfs_pkg::dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  mfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_op   (in_ch.op),
    .in_ready(in_ch.ready),
    .st      (st),
    .cmd     (cmd)
  );

  mfs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_task_id      (in_ch.task_id),
    .in_start_level  (in_ch.start_level),
    .in_burst        (in_ch.burst),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_busy_res    (out_ch.busy_res),
    .out_running_task(out_ch.running_task),
    .out_run_level   (out_ch.run_level),
    .out_finished    (out_ch.finished),
    .out_slice_start (out_ch.slice_start)
  );

endmodule

FILE: rtl/mfs_checker.sv
// Port-level assertions for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module mfs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_busy_res,
  input logic [mfs_pkg::TASK_W-1:0]  out_running_task,
  input logic [mfs_pkg::LVL_W-1:0]   out_run_level,
  input logic                        out_finished,
  input logic [mfs_pkg::TIME_W-1:0]  out_slice_start
);

  // A held result word keeps its time stamp.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slice_start))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every accepted word keeps the block busy, so no second word is accepted back to back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |->
      out_running_task == '0 && out_run_level == '0 && !out_finished)
    else $error("idle tick reports a task");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_busy_res    (out_ch.busy_res),
  .out_running_task(out_ch.running_task),
  .out_run_level   (out_ch.run_level),
  .out_finished    (out_ch.finished),
  .out_slice_start (out_ch.slice_start)
);
